@@ hw/rtl/sfg_pkg.sv @@
// Shared constants, types and register map for the stereo fade gain block.
package sfg_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 32;
  localparam int GAIN_BITS   = 16;
  localparam int ACC_BITS    = 32;
  localparam int FRAC_BITS   = 14;
  localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int CMP_BITS    = (COUNT_BITS > 32) ? COUNT_BITS : 32;
  localparam int ADDR_BITS   = 5;
  localparam int DATA_BITS   = 32;
  localparam int IDX_BITS    = ADDR_BITS - 2;
  localparam int LANES       = 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [GAIN_BITS-1:0]          gain_t;
  typedef logic [IDX_BITS-1:0]           reg_idx_t;

  localparam gain_t UNITY_GAIN = gain_t'(16384);

  localparam reg_idx_t REG_FADE_START = reg_idx_t'(0);
  localparam reg_idx_t REG_FADE_END   = reg_idx_t'(1);
  localparam reg_idx_t REG_BEGIN_GAIN = reg_idx_t'(2);
  localparam reg_idx_t REG_END_GAIN   = reg_idx_t'(3);
  localparam reg_idx_t REG_GAIN_STEP  = reg_idx_t'(4);

  // per-lane stage loads
  typedef struct packed {
    logic ld_s1;
    logic ld_s2;
  } lane_ctl_t;

endpackage

@@ hw/rtl/sfg_gain_ctrl.sv @@
// Register file, frame counter and gain ramp accumulator.
module sfg_gain_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfg_pkg::ADDR_BITS-1:0] paddr,
  input  logic [sfg_pkg::DATA_BITS-1:0] pwdata,
  output logic [sfg_pkg::DATA_BITS-1:0] prdata,
  input  logic                          accept,
  output sfg_pkg::gain_t                gain
);
  import sfg_pkg::*;

  logic [31:0]           fade_start;
  logic [31:0]           fade_end;
  gain_t                 begin_gain;
  gain_t                 end_gain;
  logic signed [31:0]    gain_step;
  logic [COUNT_BITS-1:0] frame_count;
  logic [ACC_BITS-1:0]   gain_accum;

  logic                       wr;
  reg_idx_t                   idx;
  logic                       ramp_on;
  logic [CMP_BITS-1:0]        f_ext;
  logic [CMP_BITS-1:0]        s_ext;
  logic [CMP_BITS-1:0]        e_ext;
  logic signed [ACC_BITS+1:0] sum;
  logic signed [ACC_BITS+1:0] target;
  logic signed [ACC_BITS+1:0] bounded;
  logic [ACC_BITS-1:0]        acc_clamped;
  logic [ACC_BITS-1:0]        begin_acc;
  logic [ACC_BITS-1:0]        gain_accum_next;
  gain_t                      gain_next;

  assign wr        = psel & penable & pwrite;
  assign idx       = paddr[ADDR_BITS-1:2];
  assign ramp_on   = fade_start < fade_end;
  assign f_ext     = CMP_BITS'(frame_count);
  assign s_ext     = CMP_BITS'(fade_start);
  assign e_ext     = CMP_BITS'(fade_end);
  assign begin_acc = {begin_gain, {(ACC_BITS-GAIN_BITS){1'b0}}};

  assign sum    = $signed({2'b00, gain_accum}) + $signed({{2{gain_step[31]}}, gain_step});
  assign target = $signed({2'b00, end_gain, {(ACC_BITS-GAIN_BITS){1'b0}}});

  // clamp toward the target, then into the unsigned accumulator range
  always_comb begin
    bounded = sum;
    if (begin_gain <= end_gain) begin
      if (sum > target) bounded = target;
    end else begin
      if (sum < target) bounded = target;
    end
    priority if (bounded[ACC_BITS+1]) begin
      acc_clamped = '0;
    end else if (bounded[ACC_BITS]) begin
      acc_clamped = '1;
    end else begin
      acc_clamped = bounded[ACC_BITS-1:0];
    end
  end

  always_comb begin
    gain_next       = gain_accum[ACC_BITS-1 -: GAIN_BITS];
    gain_accum_next = gain_accum;
    priority if (!ramp_on) begin
      gain_next = UNITY_GAIN;
    end else if (f_ext < s_ext) begin
      gain_next       = begin_gain;
      gain_accum_next = begin_acc;
    end else if (f_ext < e_ext) begin
      gain_accum_next = acc_clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_start  <= '0;
      fade_end    <= '0;
      begin_gain  <= UNITY_GAIN;
      end_gain    <= UNITY_GAIN;
      gain_step   <= '0;
      frame_count <= '0;
      gain_accum  <= {UNITY_GAIN, {(ACC_BITS-GAIN_BITS){1'b0}}};
    end else begin
      if (wr) begin
        case (idx)
          REG_FADE_START: fade_start <= pwdata[31:0];
          REG_FADE_END:   fade_end   <= pwdata[31:0];
          REG_BEGIN_GAIN: begin_gain <= pwdata[GAIN_BITS-1:0];
          REG_END_GAIN:   end_gain   <= pwdata[GAIN_BITS-1:0];
          REG_GAIN_STEP:  gain_step  <= $signed(pwdata[31:0]);
          default: ;
        endcase
      end
      if (wr && idx == REG_BEGIN_GAIN) begin
        gain_accum <= {pwdata[GAIN_BITS-1:0], {(ACC_BITS-GAIN_BITS){1'b0}}};
      end else if (accept) begin
        gain_accum <= gain_accum_next;
      end
      if (accept && frame_count != '1) begin
        frame_count <= frame_count + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      gain <= gain_next;
    end
  end

  always_comb begin
    case (idx)
      REG_FADE_START: prdata = DATA_BITS'(fade_start);
      REG_FADE_END:   prdata = DATA_BITS'(fade_end);
      REG_BEGIN_GAIN: prdata = DATA_BITS'(begin_gain);
      REG_END_GAIN:   prdata = DATA_BITS'(end_gain);
      REG_GAIN_STEP:  prdata = DATA_BITS'(gain_step);
      default:        prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/sfg_lane.sv @@
// One channel lane: sample register, gain multiply, round and saturate.
module sfg_lane (
  input  logic               clk,
  input  sfg_pkg::lane_ctl_t ctl,
  input  sfg_pkg::sample_t   sample_in,
  input  sfg_pkg::gain_t     gain,
  output sfg_pkg::sample_t   result,
  output logic               clip
);
  import sfg_pkg::*;

  localparam int RND_BITS = PROD_BITS + 1;
  localparam logic signed [RND_BITS-1:0] MAX_V =
    RND_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [RND_BITS-1:0] MIN_V = ~MAX_V;
  localparam logic signed [RND_BITS-1:0] HALF  = RND_BITS'(1) <<< (FRAC_BITS - 1);

  sample_t                     sample_q;
  logic signed [PROD_BITS-1:0] prod_c;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [RND_BITS-1:0]  biased;
  logic signed [RND_BITS-1:0]  rounded;
  logic signed [GAIN_BITS:0]   gain_s;

  assign gain_s = $signed({1'b0, gain});
  assign prod_c = PROD_BITS'(sample_q) * PROD_BITS'(gain_s);

  always_ff @(posedge clk) begin
    if (ctl.ld_s1) sample_q <= sample_in;
    if (ctl.ld_s2) prod <= prod_c;
  end

  // floor((p + half) / 2^FRAC_BITS): ties round up
  assign biased  = RND_BITS'(prod) + HALF;
  assign rounded = biased >>> FRAC_BITS;

  always_comb begin
    priority if (rounded > MAX_V) begin
      result = sample_t'(MAX_V);
      clip   = 1'b1;
    end else if (rounded < MIN_V) begin
      result = sample_t'(MIN_V);
      clip   = 1'b1;
    end else begin
      result = rounded[SAMPLE_BITS-1:0];
      clip   = 1'b0;
    end
  end

endmodule

@@ hw/rtl/stereo_linear_fade_gain.sv @@
// An accepted word goes through the sample, product and output word registers.
// Throughput: one word per cycle; gain ramp update and one 16x17 multiply per lane
// per stage, with stalls absorbed stage by stage so input keeps flowing into bubbles.
// Reset (rst, synchronous): pipeline empty, frame counter 0, registers at defaults,
// accumulator at begin gain; no clearing pass.
module stereo_linear_fade_gain (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfg_pkg::ADDR_BITS-1:0] paddr,
  input  logic [sfg_pkg::DATA_BITS-1:0] pwdata,
  output logic [sfg_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sfg_pkg::sample_t              left_in,
  input  sfg_pkg::sample_t              right_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sfg_pkg::sample_t              left_out,
  output sfg_pkg::sample_t              right_out,
  output logic                          clipped
);
  import sfg_pkg::*;

  logic      v1;
  logic      v2;
  logic      take_out;
  logic      take2;
  logic      take1;
  logic      accept;
  lane_ctl_t ctl;
  gain_t     gain;
  sample_t   lane_in  [LANES];
  sample_t   lane_res [LANES];
  logic [LANES-1:0] lane_clip;

  assign pready   = 1'b1;
  assign take_out = !out_valid || out_ready;
  assign take2    = !v2 || take_out;
  assign take1    = !v1 || take2;
  assign in_ready = take1;
  assign accept   = in_valid && take1;

  assign ctl.ld_s1 = accept;
  assign ctl.ld_s2 = take2 && v1;

  assign lane_in[0] = left_in;
  assign lane_in[1] = right_in;

  sfg_gain_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .accept  (accept),
    .gain    (gain)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    sfg_lane u_lane (
      .clk       (clk),
      .ctl       (ctl),
      .sample_in (lane_in[i]),
      .gain      (gain),
      .result    (lane_res[i]),
      .clip      (lane_clip[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take1)    v1        <= in_valid;
      if (take2)    v2        <= v1;
      if (take_out) out_valid <= v2;
    end
  end

  // merge: output word register, clip flag from either lane
  always_ff @(posedge clk) begin
    if (take_out && v2) begin
      left_out  <= lane_res[0];
      right_out <= lane_res[1];
      clipped   <= |lane_clip;
    end
  end

`ifndef SYNTH
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> v1)
    else $error("accepted word not held in first stage");

  a_s2_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    (v2 && out_valid && !out_ready) |=> v2)
    else $error("second stage dropped a word under stall");

  a_ready_when_s1_empty: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> in_ready)
    else $error("input not ready with empty first stage");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!out_valid && !v1 && !v2))
    else $error("pipeline not empty after reset");
`endif

endmodule

@@ tb/stereo_linear_fade_gain_test.sv @@
// Testbench for the stereo fade gain block: directed table, then random frames vs. a predictor.
`timescale 1ns / 100ps

module stereo_linear_fade_gain_test;
  import sfg_pkg::*;

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    clip;
  } frame_word_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    reg_idx_t    idx;
    logic        rel;
    logic [31:0] val;
    sample_t     left;
    sample_t     right;
    logic        typed;
    frame_word_t want;
  } plan_row_t;

  localparam int    RANDOM_FRAMES = 1300;
  localparam int    QUIET_FRAMES  = 1100;
  localparam int    HOLD_CYCLES   = 80;
  localparam int    PIPE_DEPTH    = 3;
  localparam longint ACC_MAX      = 64'h0000_0000_FFFF_FFFF;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel, penable, pwrite, pready;
  logic [ADDR_BITS-1:0]  paddr;
  logic [DATA_BITS-1:0]  pwdata, prdata;
  logic                  in_valid, in_ready, out_valid, out_ready, clipped;
  sample_t               left_in, right_in, left_out, right_out;

  stereo_linear_fade_gain dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .left_in   (left_in),
    .right_in  (right_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_out  (left_out),
    .right_out (right_out),
    .clipped   (clipped)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // fade state mirrored from the block
  logic [31:0]           ramp_first, ramp_last, gain_acc;
  logic [COUNT_BITS-1:0] frames_seen;
  gain_t                 gain_from, gain_to;
  logic signed [31:0]    gain_inc;

  frame_word_t expected_frames[$];
  plan_row_t   plan[$];
  int          mismatch_count = 0;
  bit          typed_next = 1'b0;
  frame_word_t typed_word;
  bit          hold_req = 1'b0;
  bit          quiet = 1'b0;
  bit          sender_idle = 1'b1;

  // returns {saturated, sample}
  function automatic logic [SAMPLE_BITS:0] apply_gain(input sample_t s, input gain_t g);
    longint prod, q, hi, lo;
    hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    prod = longint'(s) * longint'(g);
    q = (prod + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (q > hi) return {1'b1, sample_t'(hi)};
    if (q < lo) return {1'b1, sample_t'(lo)};
    return {1'b0, sample_t'(q)};
  endfunction

  function automatic frame_word_t predict_frame(input sample_t l, input sample_t r);
    gain_t                g;
    longint               nxt, tgt;
    logic [SAMPLE_BITS:0] a, b;
    frame_word_t          w;
    if (ramp_first >= ramp_last) begin
      g = UNITY_GAIN;
    end else if (frames_seen < ramp_first) begin
      gain_acc = {gain_from, 16'h0000};
      g = gain_from;
    end else if (frames_seen < ramp_last) begin
      g = gain_acc[31:16];
      tgt = longint'({gain_to, 16'h0000});
      nxt = longint'(gain_acc) + longint'(gain_inc);
      // clamp toward the target, then keep inside the accumulator range
      if (gain_from <= gain_to) begin
        if (nxt > tgt) nxt = tgt;
      end else if (nxt < tgt) begin
        nxt = tgt;
      end
      if (nxt < 0) nxt = 0;
      if (nxt > ACC_MAX) nxt = ACC_MAX;
      gain_acc = nxt[31:0];
    end else begin
      g = gain_acc[31:16];
    end
    a = apply_gain(l, g);
    b = apply_gain(r, g);
    w.left  = a[SAMPLE_BITS-1:0];
    w.right = b[SAMPLE_BITS-1:0];
    w.clip  = a[SAMPLE_BITS] | b[SAMPLE_BITS];
    if (frames_seen != '1) frames_seen = frames_seen + COUNT_BITS'(1);
    return w;
  endfunction

  function automatic void plan_cfg(input reg_idx_t idx, input logic rel, input logic [31:0] val);
    plan_row_t row;
    row.kind  = ROW_CFG;
    row.idx   = idx;
    row.rel   = rel;
    row.val   = val;
    row.left  = '0;
    row.right = '0;
    row.typed = 1'b0;
    row.want  = '0;
    plan.push_back(row);
  endfunction

  function automatic void plan_frame(input sample_t l, input sample_t r, input logic typed,
                                     input frame_word_t want);
    plan_row_t row;
    row.kind  = ROW_ITEM;
    row.idx   = REG_FADE_START;
    row.rel   = 1'b0;
    row.val   = '0;
    row.left  = l;
    row.right = r;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endfunction

  function automatic gain_t pick_gain();
    case ($urandom_range(0, 7))
      0:       return gain_t'(0);
      1:       return gain_t'(16'hFFFF);
      2:       return UNITY_GAIN;
      default: return gain_t'($urandom);
    endcase
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return sample_t'(16'sh7FFF);
      1:       return sample_t'(16'sh8000);
      2:       return sample_t'(0);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic program_reg(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    case (idx)
      REG_FADE_START: ramp_first = val;
      REG_FADE_END:   ramp_last = val;
      REG_BEGIN_GAIN: begin
        gain_from = val[15:0];
        gain_acc  = {val[15:0], 16'h0000};
      end
      REG_END_GAIN:   gain_to = val[15:0];
      REG_GAIN_STEP:  gain_inc = val;
      default: ;
    endcase
  endtask

  task automatic release_bus();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // valid is not lowered after a handshake, so back-to-back words keep it high
  task automatic send_frame(input sample_t l, input sample_t r);
    if (sender_idle && !quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    left_in  <= l;
    right_in <= r;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(negedge clk);
  endtask

  task automatic random_phase(input int n_frames, input bit hold);
    logic [31:0] start_at, stop_at, stepv;
    longint      span, delta;
    wait_drained();
    span     = $urandom_range(1, 90);
    start_at = frames_seen + $urandom_range(0, 40);
    stop_at  = start_at + 32'(span);
    case ($urandom_range(0, 9))
      0: stop_at = start_at - $urandom_range(0, 20);
      1: begin
        start_at = '0;
        stop_at  = '1;
      end
      2: stop_at = '1;
      default: ;
    endcase
    if ($urandom_range(0, 3) != 0) program_reg(REG_BEGIN_GAIN, 32'(pick_gain()));
    program_reg(REG_END_GAIN, 32'(pick_gain()));
    program_reg(REG_FADE_START, start_at);
    program_reg(REG_FADE_END, stop_at);
    case ($urandom_range(0, 3))
      0: stepv = $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0:       stepv = 32'h7FFF_FFFF;
          1:       stepv = 32'h8000_0000;
          2:       stepv = 32'h0000_0000;
          3:       stepv = 32'h0000_0001;
          default: stepv = 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        // slope that lands near the target, with some jitter
        delta = (longint'({gain_to, 16'h0000}) - longint'({gain_from, 16'h0000})) / span;
        stepv = 32'(delta + longint'($urandom_range(0, 4096)) - 2048);
      end
    endcase
    program_reg(REG_GAIN_STEP, stepv);
    release_bus();
    if (hold) hold_req = 1'b1;
    sender_idle = !hold;
    repeat (n_frames) send_frame(pick_sample(), pick_sample());
    sender_idle = 1'b1;
  endtask

  // result side
  initial begin
    out_ready = 1'b0;
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    frame_word_t w;
    if (!rst) begin
      if (in_valid && in_ready) begin
        w = predict_frame(left_in, right_in);
        if (typed_next) begin
          w = typed_word;
          typed_next = 1'b0;
        end
        expected_frames.push_back(w);
      end
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected output word: left %0d right %0d clip %0b",
                     left_out, right_out, clipped);
        end else begin
          w = expected_frames.pop_front();
          if (left_out !== w.left || right_out !== w.right || clipped !== w.clip) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("word mismatch: expected left %0d right %0d clip %0b, got %0d %0d %0b",
                       w.left, w.right, w.clip, left_out, right_out, clipped);
          end
        end
      end
    end
  end

  initial begin
    int sent, phase, n;
    bit bus_busy;
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    left_in  = '0;
    right_in = '0;
    ramp_first  = '0;
    ramp_last   = '0;
    gain_from   = UNITY_GAIN;
    gain_to     = UNITY_GAIN;
    gain_inc    = '0;
    frames_seen = '0;
    gain_acc    = {UNITY_GAIN, 16'h0000};

    // defaults: empty ramp, unity gain
    plan_frame(16'sh7FFF, 16'sh8000, 1'b1, {16'sh7FFF, 16'sh8000, 1'b0});
    plan_frame(16'sh8000, 16'sh7FFF, 1'b1, {16'sh8000, 16'sh7FFF, 1'b0});
    plan_frame(16'sh0000, 16'shFFFF, 1'b1, {16'sh0000, 16'shFFFF, 1'b0});
    // ahead of the ramp: fixed begin gain, max gain clips both lanes
    plan_cfg(REG_END_GAIN, 1'b0, 32'd16384);
    plan_cfg(REG_GAIN_STEP, 1'b0, 32'd0);
    plan_cfg(REG_FADE_START, 1'b1, 32'd1000);
    plan_cfg(REG_FADE_END, 1'b1, 32'd2000);
    plan_cfg(REG_BEGIN_GAIN, 1'b0, 32'h0000_FFFF);
    plan_frame(16'sh7FFF, 16'sh8000, 1'b1, {16'sh7FFF, 16'sh8000, 1'b1});
    plan_frame(16'sh0001, 16'shFFFF, 1'b0, '0);
    plan_cfg(REG_BEGIN_GAIN, 1'b0, 32'd0);
    plan_frame(16'sh7FFF, 16'sh8000, 1'b1, {16'sh0000, 16'sh0000, 1'b0});
    // half gain: rounding ties go up
    plan_cfg(REG_BEGIN_GAIN, 1'b0, 32'd8192);
    plan_frame(16'sh0001, 16'shFFFF, 1'b0, '0);
    plan_frame(16'sh0003, 16'shFFFD, 1'b0, '0);
    // rising ramp that hits the upper clamp
    plan_cfg(REG_BEGIN_GAIN, 1'b0, 32'd0);
    plan_cfg(REG_GAIN_STEP, 1'b0, 32'h1800_0000);
    plan_cfg(REG_FADE_START, 1'b1, 32'd1);
    plan_cfg(REG_FADE_END, 1'b1, 32'd5);
    repeat (5) plan_frame(16'sh7FFF, 16'sh8000, 1'b0, '0);
    // falling ramp that hits the lower clamp
    plan_cfg(REG_BEGIN_GAIN, 1'b0, 32'h0000_FFFF);
    plan_cfg(REG_END_GAIN, 1'b0, 32'h0000_1000);
    plan_cfg(REG_GAIN_STEP, 1'b0, 32'hC000_0000);
    plan_cfg(REG_FADE_START, 1'b1, 32'd0);
    plan_cfg(REG_FADE_END, 1'b1, 32'd4);
    repeat (5) plan_frame(16'sh4E20, 16'shB1E0, 1'b0, '0);
    // step against the direction: accumulator bottoms out at zero
    plan_cfg(REG_BEGIN_GAIN, 1'b0, 32'h0000_0100);
    plan_cfg(REG_END_GAIN, 1'b0, 32'h0000_8000);
    plan_cfg(REG_GAIN_STEP, 1'b0, 32'h8000_0000);
    plan_cfg(REG_FADE_START, 1'b1, 32'd0);
    plan_cfg(REG_FADE_END, 1'b1, 32'd3);
    repeat (2) plan_frame(16'sh7FFF, 16'sh8000, 1'b0, '0);
    // and tops out at all ones
    plan_cfg(REG_BEGIN_GAIN, 1'b0, 32'h0000_FF00);
    plan_cfg(REG_END_GAIN, 1'b0, 32'h0000_0100);
    plan_cfg(REG_GAIN_STEP, 1'b0, 32'h7FFF_FFFF);
    plan_cfg(REG_FADE_START, 1'b1, 32'd0);
    plan_cfg(REG_FADE_END, 1'b1, 32'd3);
    repeat (2) plan_frame(16'sh0123, 16'shFEDC, 1'b0, '0);
    // reversed ramp: unity gain
    plan_cfg(REG_FADE_START, 1'b1, 32'd10);
    plan_cfg(REG_FADE_END, 1'b1, 32'd5);
    plan_frame(16'sh7FFF, 16'sh8000, 1'b1, {16'sh7FFF, 16'sh8000, 1'b0});

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    bus_busy = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (!bus_busy) begin
          wait_drained();
          bus_busy = 1'b1;
        end
        program_reg(plan[i].idx, plan[i].rel ? plan[i].val + frames_seen : plan[i].val);
      end else begin
        if (bus_busy) begin
          release_bus();
          bus_busy = 1'b0;
        end
        typed_next = plan[i].typed;
        typed_word = plan[i].want;
        send_frame(plan[i].left, plan[i].right);
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_FRAMES) begin
      n = (phase == 2) ? 60 : $urandom_range(20, 110);
      if (sent + n > RANDOM_FRAMES) n = RANDOM_FRAMES - sent;
      quiet = (sent >= QUIET_FRAMES);
      random_phase(n, phase == 2);
      sent += n;
      phase++;
    end

    wait_drained();
    repeat (PIPE_DEPTH + 8) @(negedge clk);
    if (mismatch_count == 0 && expected_frames.size() == 0) begin
      $display("stereo_linear_fade_gain_test: PASS");
    end else begin
      $display("stereo_linear_fade_gain_test: FAIL");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("stereo_linear_fade_gain_test: FAIL");
    $finish;
  end

endmodule
